[src/pattern_class_search_unit_defines.svh]
// Assertion macros shared by the checker.
`ifndef PATTERN_CLASS_SEARCH_UNIT_DEFINES_SVH
`define PATTERN_CLASS_SEARCH_UNIT_DEFINES_SVH
// Implication checked on every rising clock edge outside reset.
`define PCS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pattern search check failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define PCS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pattern search check failed");
`endif

[src/pcs_pkg.sv]
// ----------------------------------------------------------------------------
// pcs_pkg
// Shared types and constants of the pattern class search unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package pcs_pkg;
  localparam int MaxTokensDef = 16;
  localparam int MaxSourceDef = 65536;

  typedef enum logic [1:0] {
    KIND_LIT  = 2'd0,
    KIND_ANY  = 2'd1,
    KIND_SET  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ESC     = 3'd1,
    PH_SETOPEN = 3'd2,
    PH_SETBODY = 3'd3,
    PH_ENDED   = 3'd4,
    PH_DONE    = 3'd5
  } phase_t;

  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChCaret = 8'h5E;
  localparam logic [7:0] ChClose = 8'h5D;

  // Control handed to every cell in the row.
  typedef struct packed {
    logic       load;     // write the token into the selected cell
    logic       step;     // shift in one source byte
    logic       clear;    // clear partial matches
    logic [7:0] ch;       // source byte
  } cell_ctl_t;
endpackage

[src/pcs_compiler.sv]
// ----------------------------------------------------------------------------
// pcs_compiler
// Parses pattern bytes into one-character tokens.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pcs_compiler #(
  parameter int MaxTokens = pcs_pkg::MaxTokensDef,
  localparam int CntW = $clog2(MaxTokens + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pat_valid,
  input  logic [7:0]          pat_ch,
  input  logic                pat_last,
  output logic                emit_valid,
  output logic [CntW-1:0]     emit_idx,
  output pcs_pkg::kind_t      emit_kind,
  output logic [255:0]        emit_set,
  output logic [CntW-1:0]     token_total,
  output logic                overflow,
  output logic                done,
  output logic                pattern_end
);
  pcs_pkg::phase_t phase_r, phase_nxt;
  logic [CntW-1:0] total_r, total_nxt;
  logic            ovf_r, ovf_nxt;
  logic [255:0]    work_r, work_nxt;
  logic            neg_r, neg_nxt;
  logic            em;
  pcs_pkg::kind_t  em_kind;
  logic [255:0]    em_set;
  pcs_pkg::phase_t ph;
  logic [CntW-1:0] tot;
  logic            ovf;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= pcs_pkg::PH_IDLE;
      total_r <= '0;
      ovf_r   <= 1'b0;
      neg_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      total_r <= total_nxt;
      ovf_r   <= ovf_nxt;
      neg_r   <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  always_comb begin
    ph       = phase_r;
    tot      = total_r;
    ovf      = ovf_r;
    work_nxt = work_r;
    neg_nxt  = neg_r;
    em       = 1'b0;
    em_kind  = pcs_pkg::KIND_NONE;
    em_set   = '0;
    if (pat_valid) begin
      if (ph == pcs_pkg::PH_DONE) begin
        tot = '0;
        ovf = 1'b0;
        ph  = pcs_pkg::PH_IDLE;
      end
      unique case (ph)
        pcs_pkg::PH_IDLE: begin
          if (pat_ch == 8'h00) begin
            ph = pcs_pkg::PH_ENDED;
          end else if (pat_ch == pcs_pkg::ChDot) begin
            em = 1'b1;
            em_kind = pcs_pkg::KIND_ANY;
          end else if (pat_ch == pcs_pkg::ChBsl) begin
            ph = pcs_pkg::PH_ESC;
          end else if (pat_ch == pcs_pkg::ChOpen) begin
            work_nxt = '0;
            neg_nxt  = 1'b0;
            ph = pcs_pkg::PH_SETOPEN;
          end else begin
            em = 1'b1;
            em_kind = pcs_pkg::KIND_LIT;
            em_set[pat_ch] = 1'b1;
          end
        end
        pcs_pkg::PH_ESC: begin
          em = 1'b1;
          if (pat_ch == pcs_pkg::ChLowA || pat_ch == pcs_pkg::ChUpA) begin
            em_kind = pcs_pkg::KIND_SET;
            for (int k = 0; k < 26; k++) begin
              em_set[pat_ch + 8'(k)] = 1'b1;
            end
          end
          ph = (pat_ch == 8'h00) ? pcs_pkg::PH_ENDED : pcs_pkg::PH_IDLE;
        end
        pcs_pkg::PH_SETOPEN, pcs_pkg::PH_SETBODY: begin
          if (ph == pcs_pkg::PH_SETOPEN && pat_ch == pcs_pkg::ChCaret) begin
            neg_nxt = 1'b1;
            ph = pcs_pkg::PH_SETBODY;
          end else if (pat_ch == 8'h00) begin
            em = 1'b1;
            ph = pcs_pkg::PH_ENDED;
          end else if (pat_ch == pcs_pkg::ChClose) begin
            em = 1'b1;
            em_kind = pcs_pkg::KIND_SET;
            em_set = neg_r ? ~work_r : work_r;
            ph = pcs_pkg::PH_IDLE;
          end else begin
            work_nxt[pat_ch] = 1'b1;
            ph = pcs_pkg::PH_SETBODY;
          end
        end
        default: begin
        end
      endcase
      // An open escape or bracket at the end of the pattern adds a dead token.
      // It cannot coincide with another emit, since those leave those phases.
      if (pat_last) begin
        if (ph == pcs_pkg::PH_ESC || ph == pcs_pkg::PH_SETOPEN ||
            ph == pcs_pkg::PH_SETBODY) begin
          em = 1'b1;
          em_kind = pcs_pkg::KIND_NONE;
          em_set = '0;
        end
        ph = pcs_pkg::PH_DONE;
      end
    end
    emit_idx = tot;
    emit_valid = 1'b0;
    if (em) begin
      if (tot >= CntW'(MaxTokens)) begin
        ovf = 1'b1;
      end else begin
        emit_valid = 1'b1;
        tot = tot + 1'b1;
      end
    end
    emit_kind = em_kind;
    emit_set  = em_set;
    phase_nxt = ph;
    total_nxt = tot;
    ovf_nxt   = ovf;
  end

  assign token_total = total_r;
  assign overflow    = ovf_r;
  assign done        = (phase_r == pcs_pkg::PH_DONE);
  assign pattern_end = pat_valid && pat_last;
endmodule

[src/pcs_cell.sv]
// ----------------------------------------------------------------------------
// pcs_cell
// One token of the pattern and its shift-and match bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pcs_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  pcs_pkg::cell_ctl_t ctl,
  input  logic               sel,
  input  pcs_pkg::kind_t     load_kind,
  input  logic [255:0]       load_set,
  input  logic               prev_match,
  output logic               match
);
  pcs_pkg::kind_t kind_r;
  logic [255:0]   set_r;
  logic           match_r, match_nxt;
  logic           acc;

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      kind_r <= load_kind;
      set_r  <= load_set;
    end
  end

  always_comb begin
    unique case (kind_r)
      pcs_pkg::KIND_ANY:  acc = 1'b1;
      pcs_pkg::KIND_NONE: acc = 1'b0;
      default:            acc = set_r[ctl.ch];
    endcase
    match_nxt = match_r;
    if (ctl.clear) begin
      match_nxt = 1'b0;
    end else if (ctl.step) begin
      match_nxt = prev_match && acc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match = match_r;
endmodule

[src/pattern_class_search_unit.sv]
// ----------------------------------------------------------------------------
// pattern_class_search_unit
// Single-character-class pattern search over a byte stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// The block takes one beat per clock cycle while the input is not held
// off, pattern beats and source beats alike, with no pause between them.
// Pattern beats (op 0) are parsed into up to MaxTokens tokens by the
// compiler; each token lands in one cell of a row, and every cell holds its
// token's 256-bit byte set plus one shift-and match bit that is handed to
// the next cell on every source beat. All cells compare the source byte in
// parallel. The result beat for the last source byte passes through the
// registered row bits, on which hit detection works, and then the output
// register. A second result register sits behind the output register and
// catches a result that arrives while the output is stalled. The input is
// held off only while that second register is full, or while a result is
// about to land on a full, stalled output register. Source beats before any
// pattern is finished produce nothing.
module pattern_class_search_unit #(
  parameter int MaxTokens = pcs_pkg::MaxTokensDef,
  parameter int MaxSource = pcs_pkg::MaxSourceDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // ch[7:0]
  input  logic        in_tuser,   // op
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // found[0], match_start[16:1], pattern_bad[17]
);
  localparam int CntW = $clog2(MaxTokens + 1);
  localparam int PosW = $clog2(MaxSource);
  localparam int HitW = (PosW > 16) ? PosW : 16;

  logic                 acc;
  logic                 pat_v, src_v;
  logic                 emit_valid;
  logic [CntW-1:0]      emit_idx;
  pcs_pkg::kind_t       emit_kind;
  logic [255:0]         emit_set;
  logic [CntW-1:0]      total;
  logic                 ovf, done, pend;
  pcs_pkg::cell_ctl_t   ctl;
  logic [MaxTokens:0]   chain;
  logic [PosW-1:0]      idx_r, idx_nxt;
  logic                 hit_r, hit_nxt;
  logic [HitW-1:0]      first_r, first_nxt;
  logic                 ov_r;
  logic                 ov_found_r, ov_bad_r;
  logic [15:0]          ov_start_r;
  logic                 sk_r;
  logic                 sk_found_r, sk_bad_r;
  logic [15:0]          sk_start_r;
  logic                 res_wr;
  logic [15:0]          res_start;
  logic                 pend_r;
  logic                 pend_last_r;
  logic [PosW-1:0]      pend_pos_r;
  logic                 last_hit;
  logic                 hit_f;
  logic [HitW-1:0]      first_f;
  logic [HitW-1:0]      cand;

  // A result is written when the beat of the previous cycle ended a search.
  assign res_wr    = pend_r && pend_last_r;
  assign in_tready = !sk_r && !(ov_r && !out_tready && res_wr);
  assign acc   = in_tvalid && in_tready;
  assign pat_v = acc && !in_tuser;
  assign src_v = acc && in_tuser && done;

  pcs_compiler #(.MaxTokens(MaxTokens)) u_comp (
    .clk, .rst_n,
    .pat_valid(pat_v), .pat_ch(in_tdata), .pat_last(in_tlast),
    .emit_valid, .emit_idx, .emit_kind, .emit_set,
    .token_total(total), .overflow(ovf), .done, .pattern_end(pend)
  );

  always_comb begin
    ctl.load  = emit_valid;
    ctl.step  = src_v && !(pend_r && pend_last_r);
    ctl.clear = pend || (pend_r && pend_last_r);
    ctl.ch    = in_tdata;
    if (pend_r && pend_last_r && src_v) begin
      ctl.clear = 1'b0;
      ctl.step  = 1'b1;
    end
  end

  // Cell 0 sees a constant one: a new match may begin at every byte.
  // When the previous beat ended a search, the row is treated as cleared.
  assign chain[0] = 1'b1;
  for (genvar i = 0; i < MaxTokens; i++) begin : g_cell
    logic prev_m;
    assign prev_m = (i == 0) ? 1'b1 : (chain[i] && !(pend_r && pend_last_r));
    pcs_cell u_cell (
      .clk, .rst_n, .ctl,
      .sel(emit_idx == CntW'(i)),
      .load_kind(emit_kind), .load_set(emit_set),
      .prev_match(prev_m), .match(chain[i+1])
    );
  end

  // Hit detection runs in the cycle after the row updates, on the registered bits.
  always_comb begin
    last_hit = (total != '0) && chain[total];
    hit_f    = hit_r;
    first_f  = first_r;
    cand     = HitW'(pend_pos_r) - HitW'(total - 1'b1);
    if (pend_r && !hit_r) begin
      if (total == '0) begin
        hit_f   = 1'b1;
        first_f = '0;
      end else if (last_hit) begin
        hit_f   = 1'b1;
        first_f = cand;
      end
    end
    idx_nxt   = idx_r;
    hit_nxt   = hit_f;
    first_nxt = first_f;
    if (pend || (pend_r && pend_last_r)) begin
      hit_nxt   = 1'b0;
      first_nxt = '0;
      if (pend) idx_nxt = '0;
    end
    if (pend_r && pend_last_r && !pend) begin
      idx_nxt = '0;
    end
    if (src_v) begin
      if (idx_nxt != PosW'(MaxSource - 1)) idx_nxt = idx_nxt + 1'b1;
    end
  end

  assign res_start = !hit_f ? 16'd0 :
                     (first_f > HitW'(16'hFFFF)) ? 16'hFFFF : first_f[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      hit_r  <= 1'b0;
      pend_r <= 1'b0;
      ov_r   <= 1'b0;
      sk_r   <= 1'b0;
    end else begin
      idx_r  <= idx_nxt;
      hit_r  <= hit_nxt;
      pend_r <= src_v;
      // The output register refills from the second register first.
      if (!ov_r || out_tready) begin
        ov_r <= sk_r || res_wr;
        sk_r <= sk_r && res_wr;
      end else if (res_wr) begin
        sk_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    first_r     <= first_nxt;
    pend_last_r <= in_tlast;
    pend_pos_r  <= (pend_r && pend_last_r) ? '0 : idx_r;
    if (!ov_r || out_tready) begin
      if (sk_r) begin
        ov_found_r <= sk_found_r;
        ov_start_r <= sk_start_r;
        ov_bad_r   <= sk_bad_r;
      end else if (res_wr) begin
        ov_found_r <= hit_f;
        ov_start_r <= res_start;
        ov_bad_r   <= ovf;
      end
    end
    if (res_wr) begin
      sk_found_r <= hit_f;
      sk_start_r <= res_start;
      sk_bad_r   <= ovf;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, ov_bad_r, ov_start_r, ov_found_r};
endmodule

[src/pattern_class_search_unit_checker.sv]
// ----------------------------------------------------------------------------
// pattern_class_search_unit_checker
// Port-level checks of the search unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pattern_class_search_unit_defines.svh"
module pattern_class_search_unit_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata
);
  `PCS_ASSERT_IMP(a_no_found_start, clk, rst_n, out_tvalid && !out_tdata[0], out_tdata[16:1] == 16'd0)
  `PCS_ASSERT_IMP(a_pad_zero, clk, rst_n, out_tvalid, out_tdata[23:18] == 6'd0)
  `PCS_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `PCS_ASSERT_IMP(a_ready, clk, rst_n, !out_tvalid, in_tready)
endmodule

bind pattern_class_search_unit pattern_class_search_unit_checker u_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata
);

[test/pattern_class_search_unit_tb.sv]
// ----------------------------------------------------------------------------
// pattern_class_search_unit_tb
// Self-checking bench for the pattern class search unit. Patterns and source
// streams are driven as beats; a scoreboard compiles every accepted pattern
// into tokens itself and runs its own shift-and search on accepted source
// beats. Each result beat is then checked field by field against the oldest
// expected result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pattern_class_search_unit_tb;

  localparam int NumTokens = pcs_pkg::MaxTokensDef;
  localparam int SrcTop = pcs_pkg::MaxSourceDef - 1;
  localparam int CycleLimit = 3000000;
  localparam int RandomBeats = 1450;

  // Holds the expected search results and the state needed to predict them.
  class search_scoreboard;
    typedef struct {
      bit          found;
      logic [15:0] start;
      bit          bad;
    } result_t;

    pcs_pkg::kind_t  kinds[NumTokens];
    logic [255:0]    sets[NumTokens];
    int unsigned     ntok;
    pcs_pkg::phase_t phase;
    logic [15:0]     partial;
    int unsigned     src_pos;
    bit              hit;
    int unsigned     first_pos;
    bit              overflow;
    logic [255:0]    bracket;
    bit              negate;
    result_t         expected_q[$];
    int              errors;
    int              checked;

    function new();
      ntok = 0;
      phase = pcs_pkg::PH_IDLE;
      overflow = 0;
      bracket = '0;
      negate = 0;
      errors = 0;
      checked = 0;
      clear_search();
    endfunction

    function void clear_search();
      partial = '0;
      src_pos = 0;
      hit = 0;
      first_pos = 0;
    endfunction

    // Tokens past capacity are parsed but dropped, and flag the pattern.
    function void add_token(pcs_pkg::kind_t k, logic [255:0] s);
      if (ntok >= NumTokens) begin
        overflow = 1;
      end else begin
        kinds[ntok] = k;
        sets[ntok] = s;
        ntok++;
      end
    endfunction

    function void bracket_byte(logic [7:0] c);
      if (c == 8'h00) begin
        add_token(pcs_pkg::KIND_NONE, '0);
        phase = pcs_pkg::PH_ENDED;
      end else if (c == pcs_pkg::ChClose) begin
        add_token(pcs_pkg::KIND_SET, negate ? ~bracket : bracket);
        phase = pcs_pkg::PH_IDLE;
      end else begin
        bracket[c] = 1'b1;
        phase = pcs_pkg::PH_SETBODY;
      end
    endfunction

    function void pattern_beat(logic [7:0] c, bit last);
      logic [255:0] s;
      if (phase == pcs_pkg::PH_DONE) begin
        ntok = 0;
        overflow = 0;
        phase = pcs_pkg::PH_IDLE;
      end
      case (phase)
        pcs_pkg::PH_IDLE: begin
          if (c == 8'h00) begin
            phase = pcs_pkg::PH_ENDED;
          end else if (c == pcs_pkg::ChDot) begin
            add_token(pcs_pkg::KIND_ANY, '0);
          end else if (c == pcs_pkg::ChBsl) begin
            phase = pcs_pkg::PH_ESC;
          end else if (c == pcs_pkg::ChOpen) begin
            bracket = '0;
            negate = 0;
            phase = pcs_pkg::PH_SETOPEN;
          end else begin
            s = '0;
            s[c] = 1'b1;
            add_token(pcs_pkg::KIND_LIT, s);
          end
        end
        pcs_pkg::PH_ESC: begin
          if (c == pcs_pkg::ChLowA || c == pcs_pkg::ChUpA) begin
            s = '0;
            for (int k = 0; k < 26; k++) s[c + k] = 1'b1;
            add_token(pcs_pkg::KIND_SET, s);
          end else begin
            add_token(pcs_pkg::KIND_NONE, '0);
          end
          phase = (c == 8'h00) ? pcs_pkg::PH_ENDED : pcs_pkg::PH_IDLE;
        end
        pcs_pkg::PH_SETOPEN: begin
          if (c == pcs_pkg::ChCaret) begin
            negate = 1;
            phase = pcs_pkg::PH_SETBODY;
          end else begin
            bracket_byte(c);
          end
        end
        pcs_pkg::PH_SETBODY: bracket_byte(c);
        default: ;
      endcase
      if (last) begin
        // An unfinished escape or bracket adds a token that never matches.
        if (phase == pcs_pkg::PH_ESC || phase == pcs_pkg::PH_SETOPEN ||
            phase == pcs_pkg::PH_SETBODY)
          add_token(pcs_pkg::KIND_NONE, '0);
        phase = pcs_pkg::PH_DONE;
        clear_search();
      end
    endfunction

    function void source_beat(logic [7:0] c, bit last);
      int unsigned pos;
      logic [15:0] accept;
      result_t r;
      if (phase != pcs_pkg::PH_DONE) return;
      pos = src_pos;
      if (src_pos < SrcTop) src_pos++;
      accept = '0;
      for (int t = 0; t < ntok; t++)
        accept[t] = (kinds[t] == pcs_pkg::KIND_ANY) ? 1'b1 :
                    (kinds[t] == pcs_pkg::KIND_NONE) ? 1'b0 : sets[t][c];
      partial = ((partial << 1) | 16'd1) & accept;
      if (!hit) begin
        if (ntok == 0) begin
          hit = 1;
          first_pos = 0;
        end else if (partial[ntok-1]) begin
          hit = 1;
          first_pos = pos - (ntok - 1);
        end
      end
      if (last) begin
        r.found = hit;
        r.start = !hit ? 16'd0 : (first_pos > 65535) ? 16'hFFFF : first_pos[15:0];
        r.bad = overflow;
        expected_q.push_back(r);
        clear_search();
      end
    endfunction

    function void note_beat(bit op, logic [7:0] c, bit last);
      if (op) source_beat(c, last);
      else pattern_beat(c, last);
    endfunction

    function void check_result(logic [23:0] d);
      result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, d);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      checked++;
      if (d[0] !== r.found || d[16:1] !== r.start || d[17] !== r.bad) begin
        $display("%0t: result mismatch: expected found=%0d start=%0d bad=%0d,",
                 $time, r.found, r.start, r.bad);
        $display("%0t:   got found=%0d start=%0d bad=%0d",
                 $time, d[0], d[16:1], d[17]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 0;
  logic        in_tlast = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [23:0] out_tdata;

  search_scoreboard board = new();
  int  cycles = 0;
  bit  no_idle = 0;      // suppresses sender and receiver idling
  bit  hold_off = 0;     // asks the receiver for one long stall
  int  sent_beats = 0;

  always #4 clk = ~clk;

  pattern_class_search_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // Both monitors see the values from just before the edge.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_beat(in_tuser, in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("pattern_class_search_unit_tb: done, errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long stall on request so that the
  // result registers fill and the input gets back-pressured.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      out_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // Drives one beat and returns at the edge where it was taken.
  task automatic send_beat(bit op, logic [7:0] c, bit last);
    while (!no_idle && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= c;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    sent_beats++;
  endtask

  task automatic send_seq(bit op, logic [7:0] q[$]);
    foreach (q[i]) send_beat(op, q[i], i == q.size() - 1);
  endtask

  task automatic send_text(bit op, string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_seq(op, q);
  endtask

  // Builds a random pattern, mostly well formed from a small alphabet so
  // that sources hit it often, with some malformed and oversized ones.
  task automatic make_pattern(output logic [7:0] q[$]);
    int n;
    q = {};
    n = ($urandom_range(99) < 5) ? $urandom_range(17, 20) : $urandom_range(1, 4);
    for (int t = 0; t < n; t++) begin
      case ($urandom_range(9))
        0: q.push_back(pcs_pkg::ChDot);
        1: begin
          q.push_back(pcs_pkg::ChBsl);
          q.push_back($urandom_range(1) ? pcs_pkg::ChLowA : pcs_pkg::ChUpA);
        end
        2: begin
          q.push_back(pcs_pkg::ChBsl);
          q.push_back(8'($urandom_range(255)));
        end
        3: begin
          q.push_back(pcs_pkg::ChOpen);
          if ($urandom_range(1)) q.push_back(pcs_pkg::ChCaret);
          repeat ($urandom_range(0, 3)) q.push_back(8'("a" + $urandom_range(2)));
          if ($urandom_range(9) != 0) q.push_back(pcs_pkg::ChClose);
        end
        4: q.push_back(8'($urandom_range(255)));
        default: q.push_back($urandom_range(1) ? 8'("a" + $urandom_range(2))
                                               : 8'("A" + $urandom_range(2)));
      endcase
    end
    if ($urandom_range(19) == 0) q.insert(int'($urandom_range(q.size() - 1)), 8'h00);
  endtask

  task automatic make_source(output logic [7:0] q[$]);
    q = {};
    repeat ($urandom_range(1, 20)) begin
      if ($urandom_range(9) == 0) q.push_back(8'($urandom_range(255)));
      else q.push_back($urandom_range(1) ? 8'("a" + $urandom_range(2))
                                         : 8'("A" + $urandom_range(2)));
    end
  endtask

  initial begin
    logic [7:0] pat[$];
    logic [7:0] src[$];
    int start_beats;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. Source with no finished pattern yields nothing.
    send_text(1, "ab");
    send_text(0, "a.c");
    send_text(1, "xxabcazc");
    // Classes, empty and negated-empty brackets.
    send_text(0, "\\a\\A[^b][]");
    send_text(1, "qZxy");
    send_text(0, "[^]\\A");
    send_text(1, "aB");
    // Bad escapes, including one on a close bracket.
    send_text(0, "\\q");
    send_text(1, "q");
    send_text(0, "x\\]");
    send_text(1, "x]");
    // Unclosed bracket and trailing backslash.
    send_text(0, "[ab");
    send_text(1, "ab");
    send_text(0, "a\\");
    send_text(1, "a\\");
    // Zero byte ends the pattern; a lone zero is the empty pattern.
    send_seq(0, '{8'h61, 8'h00, 8'h62});
    send_text(1, "ba");
    send_seq(0, '{8'h00});
    send_seq(1, '{8'hFF, 8'h00});
    // Too many tokens, then a source dropped mid-pattern.
    send_text(0, "abcdefghijklmnopqr");
    send_text(1, "abcdefghijklmnop");
    send_beat(0, "z", 0);
    send_beat(1, "z", 1);
    send_beat(0, ".", 1);
    send_beat(1, 8'h80, 1);

    // Random part: mostly pattern then several sources, some noise.
    start_beats = sent_beats;
    while (sent_beats - start_beats < RandomBeats) begin
      no_idle = (sent_beats - start_beats) > 600 && (sent_beats - start_beats) < 800;
      if ((sent_beats - start_beats) > 300 && (sent_beats - start_beats) < 320)
        hold_off = 1;
      make_pattern(pat);
      if ($urandom_range(9) == 0) begin
        // Broken sequence: source beats in the middle of a pattern.
        send_beat(0, pat[0], 0);
        send_beat(1, 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      send_seq(0, pat);
      repeat ($urandom_range(1, 5)) begin
        make_source(src);
        send_seq(1, src);
      end
      if ($urandom_range(29) == 0) begin
        // The sender waits until every result is back.
        in_tvalid <= 1'b0;
        while (board.expected_q.size() != 0) @(posedge clk);
        @(posedge clk);
      end
    end
    no_idle = 0;

    in_tvalid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Covered %0d beats and %0d search results, with class, bracket, escape,",
             sent_beats, board.checked);
    $display("overflow, mid-pattern source and back-pressure cases.");
    if (board.errors == 0) begin
      $display("pattern_class_search_unit_tb: done, clean");
    end else begin
      $display("pattern_class_search_unit_tb: done, errors");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/pcs_pkg.sv
src/pcs_compiler.sv
src/pcs_cell.sv
src/pattern_class_search_unit.sv
src/pattern_class_search_unit_checker.sv
test/pattern_class_search_unit_tb.sv
